FILE: rtl/mrs_pkg.sv
// Package for the Modbus RTU slave responder: word types, codes, constants
// and the CRC-16 byte update. No dependencies.
package mrs_pkg;

    localparam int FRAME_LEN = 8;
    localparam int RESP_MAX  = 7;

    // action codes
    localparam logic [1:0] ACT_BYTE   = 2'd0;
    localparam logic [1:0] ACT_END    = 2'd1;
    localparam logic [1:0] ACT_SENSOR = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_VERSION  = 8'd0;
    localparam logic [7:0] CFG_HUM_BASE = 8'd1;

    // function codes
    localparam logic [7:0] FN_READ_COILS = 8'h01;
    localparam logic [7:0] FN_READ_INPUT = 8'h02;
    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_IREG  = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL = 8'h05;
    localparam logic [7:0] FN_WRITE_ADDR = 8'h06;

    // exception codes
    localparam logic [7:0] EXC_FUNC = 8'h01;
    localparam logic [7:0] EXC_ADDR = 8'h02;
    localparam logic [7:0] EXC_VAL  = 8'h03;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] VERSION_REG = 16'h07D6;
    localparam logic [15:0] COIL_ON     = 16'hFF00;
    localparam logic [7:0]  VERSION_TAG = 8'h76;
    localparam logic [7:0]  MAX_ADDRESS = 8'd247;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  rx_byte;
        logic        reed_level;
        logic [1:0]  sensor_index;
        logic [15:0] sensor_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] relay_state;
    } out_word_t;

    // one response, without its CRC
    typedef struct packed {
        logic [RESP_MAX-1:0][7:0] bytes;
        logic [2:0]               len;
        logic [1:0]               relays;
    } job_t;

    // reflected CRC-16 over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int j = 0; j < 8; j++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrs_front.sv
// Front part: collects request bytes, keeps slave state, checks the CRC
// byte by byte and builds the response job. Depends on mrs_pkg.
module mrs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  mrs_pkg::in_word_t in_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_index,
    input  logic [23:0]      cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output mrs_pkg::job_t    q_data
);
    import mrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CRC  = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  fb_reg [FRAME_LEN];
    logic [3:0]  cnt_reg;
    logic [7:0]  addr_reg, addr_next;
    logic [1:0]  relays_reg, relays_next;
    logic [15:0] sens_reg [4];
    logic [23:0] ver_reg;
    logic [15:0] hb_reg;
    logic [15:0] crc_reg;
    logic [2:0]  ci_reg;
    logic        reed_reg;
    logic        accept, frame_ok;
    job_t        job;

    assign full      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign frame_ok  = (crc_reg == {fb_reg[7], fb_reg[6]}) && (fb_reg[0] == addr_reg);
    assign q_push    = (state_reg == S_PUSH) && frame_ok && !q_full;
    assign q_data    = job;

    // response builder
    always_comb
    begin
        logic [7:0]  func;
        logic [15:0] rg, vl, rd, dh;
        logic [16:0] sum;
        logic        bitsel;
        func   = fb_reg[1];
        rg     = {fb_reg[2], fb_reg[3]};
        vl     = {fb_reg[4], fb_reg[5]};
        sum    = {1'b0, rg} + {1'b0, vl};
        dh     = rg - hb_reg;
        rd     = 16'h0000;
        bitsel = rg[0];
        job.bytes      = '0;
        job.bytes[0]   = addr_reg;
        job.bytes[1]   = func;
        job.len        = 3'd3;
        addr_next      = addr_reg;
        relays_next    = relays_reg;
        job.bytes[2]   = EXC_FUNC;
        job.bytes[1]   = func | 8'h80;
        case (func)
            FN_READ_COILS:
            begin
                if (vl == 16'h0000 || sum > 17'd2)
                    job.bytes[2] = EXC_ADDR;
                else
                begin
                    job.bytes[1] = func;
                    job.bytes[2] = 8'h01;
                    job.bytes[3] = (vl == 16'd2) ? {6'd0, relays_reg}
                                                 : {7'd0, relays_reg[bitsel]};
                    job.len = 3'd4;
                end
            end
            FN_READ_INPUT:
            begin
                job.bytes[1] = func;
                job.bytes[2] = 8'h01;
                job.bytes[3] = {7'd0, !reed_reg};
                job.len = 3'd4;
            end
            FN_READ_HOLD:
            begin
                if (rg == VERSION_REG)
                begin
                    job.bytes[1] = func;
                    job.bytes[2] = 8'h04;
                    job.bytes[3] = VERSION_TAG;
                    job.bytes[4] = ver_reg[23:16];
                    job.bytes[5] = ver_reg[15:8];
                    job.bytes[6] = ver_reg[7:0];
                    job.len = 3'd7;
                end
                else if (rg == 16'h0000)
                begin
                    job.bytes[1] = func;
                    job.bytes[2] = 8'h02;
                    job.bytes[3] = 8'h00;
                    job.bytes[4] = addr_reg;
                    job.len = 3'd5;
                end
                else
                    job.bytes[2] = EXC_ADDR;
            end
            FN_READ_IREG:
            begin
                if (rg < 16'd2 || (rg >= hb_reg && dh < 16'd2))
                begin
                    rd = (rg < 16'd2) ? sens_reg[{1'b0, rg[0]}] : sens_reg[{1'b1, dh[0]}];
                    job.bytes[1] = func;
                    job.bytes[2] = 8'h02;
                    job.bytes[3] = rd[15:8];
                    job.bytes[4] = rd[7:0];
                    job.len = 3'd5;
                end
                else
                    job.bytes[2] = EXC_ADDR;
            end
            FN_WRITE_COIL:
            begin
                if (rg > 16'd1)
                    job.bytes[2] = EXC_ADDR;
                else if (vl == COIL_ON || vl == 16'h0000)
                begin
                    relays_next[bitsel] = (vl == COIL_ON);
                    job.bytes[1] = func;
                    job.bytes[2] = fb_reg[2];
                    job.bytes[3] = fb_reg[3];
                    job.bytes[4] = fb_reg[4];
                    job.bytes[5] = fb_reg[5];
                    job.len = 3'd6;
                end
                else
                    job.bytes[2] = EXC_VAL;
            end
            FN_WRITE_ADDR:
            begin
                if (rg != 16'h0000)
                    job.bytes[2] = EXC_ADDR;
                else if (vl == 16'h0000 || vl > {8'd0, MAX_ADDRESS})
                    job.bytes[2] = EXC_VAL;
                else
                begin
                    addr_next = vl[7:0];
                    job.bytes[1] = func;
                    job.bytes[2] = fb_reg[2];
                    job.bytes[3] = fb_reg[3];
                    job.bytes[4] = fb_reg[4];
                    job.bytes[5] = fb_reg[5];
                    job.len = 3'd6;
                end
            end
            default:
                job.bytes[2] = EXC_FUNC;
        endcase
        job.relays = relays_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && in_data.action == ACT_END && cnt_reg == 4'(FRAME_LEN))
                    state_next = S_CRC;
            S_CRC:
                if (ci_reg == 3'd5)
                    state_next = S_PUSH;
            S_PUSH:
                if (!frame_ok || !q_full)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            addr_reg   <= 8'd1;
            relays_reg <= '0;
            ver_reg    <= '0;
            hb_reg     <= 16'd2;
            ci_reg     <= '0;
            for (int i = 0; i < 4; i++)
                sens_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == CFG_VERSION)
                ver_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_HUM_BASE)
                hb_reg <= cfg_data[15:0];
            if (accept)
            begin
                case (in_data.action)
                    ACT_BYTE:
                        if (!(cnt_reg == 4'd0 && in_data.rx_byte != addr_reg))
                            cnt_reg <= (cnt_reg < 4'(FRAME_LEN)) ? cnt_reg + 4'd1
                                                                 : 4'(FRAME_LEN + 1);
                    ACT_END:
                        cnt_reg <= '0;
                    ACT_SENSOR:
                        sens_reg[in_data.sensor_index] <= in_data.sensor_value;
                    default:
                        ;
                endcase
            end
            if (state_reg == S_IDLE)
                ci_reg <= '0;
            else if (state_reg == S_CRC)
                ci_reg <= ci_reg + 3'd1;
            if (q_push)
            begin
                addr_reg   <= addr_next;
                relays_reg <= relays_next;
            end
        end
    end

    // frame bytes and CRC check datapath
    always_ff @(posedge clk)
    begin
        if (accept && in_data.action == ACT_BYTE && cnt_reg < 4'(FRAME_LEN)
            && !(cnt_reg == 4'd0 && in_data.rx_byte != addr_reg))
            fb_reg[cnt_reg[2:0]] <= in_data.rx_byte;
        if (accept && in_data.action == ACT_END)
        begin
            crc_reg  <= CRC_INIT;
            reed_reg <= in_data.reed_level;
        end
        else if (state_reg == S_CRC)
            crc_reg <= crc_byte(crc_reg, fb_reg[ci_reg]);
    end

endmodule

FILE: rtl/mrs_queue.sv
// Two-entry job queue between front and back parts. Depends on mrs_pkg.
module mrs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  mrs_pkg::job_t wr_data,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output mrs_pkg::job_t rd_data
);
    import mrs_pkg::*;

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_data = mem[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
            mem[wp_reg] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !q_full)
                wp_reg <= !wp_reg;
            if (rd && !q_empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
        end
    end

endmodule

FILE: rtl/mrs_back.sv
// Back part: sends one job byte per pop and appends its CRC, low byte
// first. Depends on mrs_pkg.
module mrs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mrs_pkg::job_t     q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output mrs_pkg::out_word_t out_data
);
    import mrs_pkg::*;

    job_t        job_reg;
    logic        active_reg;
    logic [3:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        in_body, is_last, take;

    assign q_pop   = !active_reg && !q_empty;
    assign empty   = !active_reg;
    assign in_body = idx_reg < {1'b0, job_reg.len};
    assign is_last = idx_reg == ({1'b0, job_reg.len} + 4'd1);
    assign take    = pop && active_reg;

    // output word
    always_comb
    begin
        if (in_body)
            out_data.tx_byte = job_reg.bytes[idx_reg[2:0]];
        else if (is_last)
            out_data.tx_byte = crc_reg[15:8];
        else
            out_data.tx_byte = crc_reg[7:0];
        out_data.last        = is_last;
        out_data.relay_state = job_reg.relays;
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (q_pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 4'd1;
            if (is_last)
                active_reg <= 1'b0;
        end
    end

    // job and running CRC
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
            crc_reg <= CRC_INIT;
        end
        else if (take && in_body)
            crc_reg <= crc_byte(crc_reg, job_reg.bytes[idx_reg[2:0]]);
    end

endmodule

FILE: rtl/modbus_rtu_slave_responder.sv
// Modbus RTU slave responder top level: front part, job queue, back part.
// Depends on mrs_pkg, mrs_front, mrs_queue and mrs_back.
//
// Received-byte and sensor-update words never stall the input. A frame-end
// word for a full 8-byte request raises full after the edge that takes it,
// while the front checks the request CRC one byte per cycle over the first
// six bytes, then builds the response and waits for a slot in the two-entry
// job queue, dropping a request whose CRC or address does not match.
// Responses (5 to 9 words, the last marked by last) leave the back part one
// word per pop, with empty high between them, while the front keeps taking
// new words. Configuration writes are always ready and take effect at once.
module modbus_rtu_slave_responder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mrs_pkg::in_word_t  in_data,
    output logic               empty,
    input  logic               pop,
    output mrs_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import mrs_pkg::*;

    job_t wr_job, rd_job;
    logic q_wr, q_full, q_rd, q_empty;

    mrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_wr),
        .q_data    (wr_job)
    );

    mrs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (wr_job),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rd_data (rd_job)
    );

    mrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (rd_job),
        .q_pop    (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

endmodule

FILE: rtl/mrs_checker.sv
// Port-level checks for modbus_rtu_slave_responder, bound to the top level.
// Depends on mrs_pkg.
module mrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input mrs_pkg::in_word_t  in_data,
    input logic               empty,
    input logic               pop,
    input mrs_pkg::out_word_t out_data
);
    import mrs_pkg::*;

    // a waiting word holds while not popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("stalled response word changed");

    // a response continues without a gap and with one relay state
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !out_data.last) |=>
        (!empty && out_data.relay_state == $past(out_data.relay_state)))
        else $error("response broken before its last word");

    // byte and sensor words never stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (in_data.action == ACT_BYTE || in_data.action == ACT_SENSOR))
        |=> !full)
        else $error("input stalled after a byte or sensor word");

endmodule

bind modbus_rtu_slave_responder mrs_checker u_mrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
);
